@@ src/isseq_pkg.sv @@
// Package for the idle and standby sequencer: request types, configuration
// and state records, mode codes and timing constants.
// No dependencies.
`default_nettype none

package isseq_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int PRESCALE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PRESCALE_W-1:0] PRESCALE_TOP = PRESCALE_W'(TICKS_PER_SECOND - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT_S = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY_MS = 2'd3;

    localparam logic [14:0] DEADZONE_RST       = 15'd10;
    localparam logic [15:0] IDLE_TIMEOUT_S_RST = 16'd120;
    localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd1000;
    localparam logic [15:0] SLEEP_DELAY_MS_RST = 16'd1000;

    typedef enum logic [2:0] {
        MODE_ARM      = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_WAIT_REL = 3'd2,
        MODE_INDICATE = 3'd3,
        MODE_DELAY    = 3'd4,
        MODE_ASLEEP   = 3'd5
    } t_mode;

    typedef struct packed {
        logic signed [15:0] joy_x;
        logic signed [15:0] joy_y;
        logic               boot_released;
        logic               boot_changed;
        logic [15:0]        press_ms;
        logic               scan_done;
    } t_in_req;

    typedef struct packed {
        logic       disconnect_request;
        logic       indicate_start;
        logic       shutdown;
        logic       client_busy;
        logic [2:0] standby_mode;
    } t_out_req;

    typedef struct packed {
        logic [14:0] deadzone;
        logic [15:0] idle_timeout_s;
        logic [15:0] long_press_ms;
        logic [15:0] sleep_delay_ms;
    } t_cfg;

    typedef struct packed {
        t_mode                 mode;
        logic [15:0]           idle_seconds;
        logic [PRESCALE_W-1:0] ms_prescale;
        logic [15:0]           standby_elapsed;
        logic                  busy;
    } t_state;

endpackage

`default_nettype wire

@@ src/isseq_cfg.sv @@
// Configuration register bank of the idle and standby sequencer.
// Depends on isseq_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module isseq_cfg
    import isseq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone       <= DEADZONE_RST;
            r_cfg.idle_timeout_s <= IDLE_TIMEOUT_S_RST;
            r_cfg.long_press_ms  <= LONG_PRESS_MS_RST;
            r_cfg.sleep_delay_ms <= SLEEP_DELAY_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADZONE:       r_cfg.deadzone       <= i_cfg_data[14:0];
                CFG_IDLE_TIMEOUT_S: r_cfg.idle_timeout_s <= i_cfg_data;
                CFG_LONG_PRESS_MS:  r_cfg.long_press_ms  <= i_cfg_data;
                CFG_SLEEP_DELAY_MS: r_cfg.sleep_delay_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/isseq_step.sv @@
// Next-state and result logic for one millisecond tick of the sequencer.
// Depends on isseq_pkg for t_in_req, t_out_req, t_cfg, t_state and modes.
`default_nettype none

module isseq_step
    import isseq_pkg::*;
(
    input  wire t_in_req i_req,
    input  wire t_cfg    i_cfg,
    input  wire t_state  i_state,
    output t_state   o_state,
    output t_out_req o_res
);

    always_comb begin
        logic signed [16:0] dz;
        logic signed [16:0] neg_dz;
        logic signed [16:0] jx;
        logic signed [16:0] jy;
        logic               active;
        logic               centred;
        t_state             n;
        logic               disc;
        logic               ind;
        logic               shut;

        dz      = $signed({2'b00, i_cfg.deadzone});
        neg_dz  = -dz;
        jx      = $signed({i_req.joy_x[15], i_req.joy_x});
        jy      = $signed({i_req.joy_y[15], i_req.joy_y});
        active  = (jx > dz) || (jx < neg_dz) || (jy > dz) || (jy < neg_dz);
        centred = (jx < dz) && (jx > neg_dz) && (jy < dz) && (jy > neg_dz);

        n    = i_state;
        disc = 1'b0;
        ind  = 1'b0;
        shut = 1'b0;

        if (n.standby_elapsed != 16'hFFFF) begin
            n.standby_elapsed = n.standby_elapsed + 16'd1;
        end

        if (i_req.scan_done) begin
            n.standby_elapsed = 16'd0;
            if (n.mode != MODE_DELAY) begin
                n.mode = MODE_INDICATE;
            end
        end

        if (i_state.ms_prescale == PRESCALE_TOP) begin
            n.ms_prescale = '0;
            if (n.idle_seconds != 16'hFFFF) begin
                n.idle_seconds = n.idle_seconds + 16'd1;
            end
            if (n.idle_seconds > i_cfg.idle_timeout_s) begin
                n.idle_seconds    = 16'd0;
                disc              = 1'b1;
                n.standby_elapsed = 16'd0;
                if (n.mode != MODE_DELAY) begin
                    n.mode = MODE_INDICATE;
                end
            end
        end else begin
            n.ms_prescale = i_state.ms_prescale + PRESCALE_W'(1);
        end

        if (active) begin
            n.idle_seconds = 16'd0;
        end

        case (n.mode)
            MODE_ARM: begin
                if (i_req.boot_released) begin
                    n.mode = MODE_ARMED;
                end
            end
            MODE_ARMED: begin
                if (!i_req.boot_released && (i_req.press_ms >= i_cfg.long_press_ms)
                        && centred) begin
                    disc              = 1'b1;
                    n.standby_elapsed = 16'd0;
                    n.mode            = MODE_WAIT_REL;
                end
            end
            MODE_WAIT_REL: begin
                if (i_req.boot_changed && i_req.boot_released) begin
                    n.standby_elapsed = 16'd0;
                    n.mode            = MODE_INDICATE;
                end
            end
            MODE_INDICATE: begin
                ind               = 1'b1;
                n.standby_elapsed = 16'd0;
                n.mode            = MODE_DELAY;
            end
            MODE_DELAY: begin
                if (n.standby_elapsed > i_cfg.sleep_delay_ms) begin
                    n.standby_elapsed = 16'd0;
                    n.mode            = MODE_ASLEEP;
                    shut              = 1'b1;
                    n.busy            = 1'b0;
                end
            end
            default: ;
        endcase

        o_state                  = n;
        o_res.disconnect_request = disc;
        o_res.indicate_start     = ind;
        o_res.shutdown           = shut;
        o_res.client_busy        = n.busy;
        o_res.standby_mode       = n.mode;
    end

endmodule

`default_nettype wire

@@ src/idle_standby_sequencer.sv @@
// Top level of the idle and standby sequencer: input register, sequencer
// state, result register. Depends on isseq_pkg, isseq_cfg and isseq_step.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_stall        i_in_req  (t_in_req)
//   result    out        o_out_valid / i_out_stall      o_out_req (t_out_req)
//   config    in         i_cfg_we                       i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the result is not stalled; a request
// passes from acceptance through the input register and the step logic into
// the result register before hand-over.
// Reset is synchronous; nothing is pending after it.
// A stalled result holds the step logic; the input register then stalls too.
`default_nettype none

module idle_standby_sequencer
    import isseq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_req               i_in_req,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_req                   o_out_req,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_state   r_state;
    t_state   n_state;
    t_out_req n_res;
    logic     r_in_vld;
    t_in_req  r_in;
    logic     r_out_vld;
    t_out_req r_out;
    logic     advance;
    logic     in_take;

    isseq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    isseq_step u_step (
        .i_req   (r_in),
        .i_cfg   (cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= MODE_ARM;
            r_state.idle_seconds    <= 16'd0;
            r_state.ms_prescale     <= '0;
            r_state.standby_elapsed <= 16'd0;
            r_state.busy            <= 1'b1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire

@@ src/isseq_checker.sv @@
// Port-level checks on the idle and standby sequencer, bound to its top level.
// Depends on isseq_pkg for t_in_req and t_out_req.
`default_nettype none

module isseq_checker
    import isseq_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_in_req  i_in_req,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_req o_out_req
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_req))
        else $error("input request dropped or changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("result request dropped or changed while stalled");

    a_shutdown_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.shutdown |->
            o_out_req.standby_mode == MODE_ASLEEP && !o_out_req.client_busy)
        else $error("shutdown without asleep mode and cleared busy");

    a_indicate_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.indicate_start |-> o_out_req.standby_mode == MODE_DELAY)
        else $error("indication start outside the delay mode");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.standby_mode != 3'd6 && o_out_req.standby_mode != 3'd7)
        else $error("unreachable sequencer mode reported");

endmodule

bind idle_standby_sequencer isseq_checker u_isseq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

`default_nettype wire
